// ===== hdl/cwf_pkg.sv =====
// Shared types and constants for the channel word to float converter.
// No dependencies.
`default_nettype none
package cwf_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned ChanW = 4;

  typedef enum logic [1:0] {
    CODE_UINT  = 2'd0,
    CODE_SINT  = 2'd1,
    CODE_FLOAT = 2'd2,
    CODE_FIXED = 2'd3
  } type_code_t;

  localparam logic [0:0] REG_TYPE_LOW  = 1'b0;
  localparam logic [0:0] REG_TYPE_HIGH = 1'b1;

  // Decoded item between the input stage and the packer
  typedef struct packed {
    type_code_t       code;
    logic             neg;
    logic [WordW-1:0] mag;
    logic [WordW-1:0] word;
    logic [ChanW-1:0] chan;
  } item_t;
endpackage
`default_nettype wire

// ===== hdl/channel_word_to_float.sv =====
// Top level: config registers, input stage, packer, output skid.
// Depends on cwf_pkg and cwf_pack.
//
//   channel | tdata (low bit first)        | role
//   in_     | channel[3:0], raw_word[35:4] | words to convert
//   out_    | channel_out[3:0], float[35:4]| single-precision results
//   cfg_    | index 0 type low, 1 type high| type code masks
// Beats go to out_r, or skid_r on a stall; one beat per cycle while in_tready is high.
// The normalize/round path in cwf_pack sets the timing.
// rst_n clears valid bits and both masks. in_tready drops only while the skid
// register holds a beat; a stalled output register sends the beat in flight to the skid.
`default_nettype none
module channel_word_to_float #(
  parameter int unsigned CHANNELS      = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // channel[3:0], raw_word[35:4], zero pad
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // channel_out[3:0], float_bits[35:4], zero pad
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [0:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  logic [15:0] tsel_lo_r, tsel_hi_r;
  logic [35:0] out_r, skid_r, res;
  logic        out_v_r, skid_v_r;
  cwf_pkg::item_t item;
  logic [31:0] fb;
  logic [3:0]  ch;
  logic [31:0] w;
  logic        in_ok;

  assign cfg_ready = 1'b1;
  assign ch = in_tdata[3:0];
  assign w  = in_tdata[35:4];

  always_comb begin
    logic lo, hi;
    lo = 1'b0; hi = 1'b0;
    if (32'(ch) < CHANNELS) begin
      lo = tsel_lo_r[ch];
      hi = tsel_hi_r[ch];
    end
    item.code = cwf_pkg::type_code_t'({hi, lo});
    item.neg  = (item.code == cwf_pkg::CODE_UINT) ? 1'b0 : w[31];
    item.mag  = item.neg ? (32'd0 - w) : w;
    item.word = w;
    item.chan = ch;
  end

  cwf_pack #(.FRACTION_BITS(FRACTION_BITS)) u_pack (.item(item), .float_bits(fb));
  assign res = {fb, ch};

  assign in_tready  = ~skid_v_r;
  assign in_ok      = in_tvalid & in_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsel_lo_r <= '0;
      tsel_hi_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cwf_pkg::REG_TYPE_LOW:  tsel_lo_r <= cfg_data;
        cwf_pkg::REG_TYPE_HIGH: tsel_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || out_tready) begin
        // advance: skid first, else the new beat
        if (skid_v_r) begin
          out_r    <= skid_r;
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_r   <= res;
          out_v_r <= in_ok;
        end
      end else if (in_ok) begin
        skid_r   <= res;
        skid_v_r <= 1'b1;
      end
    end
  end

  a_skid_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid full with empty output");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r && $stable(out_r)) else $error("result lost");
  a_zero: assert property (@(posedge clk)
    item.mag == '0 && item.code != cwf_pkg::CODE_FLOAT |-> fb == '0)
    else $error("zero not +0");
endmodule
`default_nettype wire

// ===== hdl/cwf_pack.sv =====
// Normalize, round to nearest even and pack a single-precision pattern; float items pass through.
// Depends on cwf_pkg.
`default_nettype none
module cwf_pack #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire cwf_pkg::item_t item,
  output logic [31:0]         float_bits
);
  logic [4:0]  msb;
  logic [31:0] norm;
  logic [23:0] sig;
  logic        rnd;
  logic [24:0] sig_r1;
  logic [7:0]  expo;
  logic [7:0]  fbias;
  logic [31:0] packed_v;

  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (item.mag[i]) msb = 5'(i);
    end
  end

  always_comb begin
    // shift leading one to bit 31; bits below 8 are guard and sticky
    norm   = item.mag << (5'd31 - msb);
    sig    = norm[31:8];
    rnd    = norm[7] & ((|norm[6:0]) | sig[0]);
    sig_r1 = {1'b0, sig} + 25'(rnd);
    fbias  = (item.code == cwf_pkg::CODE_FIXED) ? 8'(FRACTION_BITS % 32) : 8'd0;
    expo   = 8'(msb) + 8'd127 - fbias + 8'(sig_r1[24]);
    if (item.mag == '0) packed_v = '0;
    else packed_v = {item.neg, expo, sig_r1[24] ? sig_r1[23:1] : sig_r1[22:0]};
    float_bits = (item.code == cwf_pkg::CODE_FLOAT) ? item.word : packed_v;
  end
endmodule
`default_nettype wire
